@@ sv/column_sum_accumulator_macros.svh @@
// Assertion macros for the column-sum accumulator.
`ifndef COLUMN_SUM_ACCUMULATOR_MACROS_SVH
`define COLUMN_SUM_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CSA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/csa_pkg.sv @@
// Shared constants and types of the column-sum accumulator.
package csa_pkg;
   localparam int MAX_COLUMNS = 4096;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int COLS_W      = COL_W + 1;
   localparam int ROWS_W      = 16;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 32;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = CSR_IDX_W'(1);

   localparam logic [COLS_W-1:0] COLUMN_COUNT_RESET = COLS_W'(4096);
   localparam logic [ROWS_W-1:0] ROW_COUNT_RESET    = ROWS_W'(1);

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first_row;
      logic             last_row;
      logic             last_col;
      logic             single_col;
   } pos_type;
endpackage

@@ sv/csa_interfaces.sv @@
// Channel interfaces: sample input, sum output, register write.
interface csa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [csa_pkg::SAMPLE_W-1:0]   sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface csa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [csa_pkg::SUM_W-1:0]      column_sum;
   logic [csa_pkg::COL_W-1:0]             column_index;
   logic                                  last_column;
   modport source (output valid, output column_sum, output column_index,
                   output last_column, input ready);
   modport sink (input valid, input column_sum, input column_index,
                 input last_column, output ready);
endinterface

interface csa_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [csa_pkg::CSR_IDX_W-1:0]         index;
   logic [csa_pkg::CSR_DATA_W-1:0]        data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/csa_position.sv @@
// Column and row position tracking for the sample stream.
module csa_position (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        clear,
   input  logic [csa_pkg::COLS_W-1:0]  cfg_cols,
   input  logic [csa_pkg::ROWS_W-1:0]  cfg_rows,
   output csa_pkg::pos_type            cur
);
   logic [csa_pkg::COL_W-1:0]  col_pos_ff, col_pos_in;
   logic [csa_pkg::ROWS_W-1:0] row_pos_ff, row_pos_in;
   logic [csa_pkg::COLS_W-1:0] eff_cols;
   logic [csa_pkg::ROWS_W-1:0] eff_rows;
   logic [csa_pkg::COL_W-1:0]  col;
   logic [csa_pkg::ROWS_W-1:0] row;
   logic                       last_row;
   logic                       last_col;

   // zero or oversize column count means a full-length row
   assign eff_cols = (cfg_cols == '0 || cfg_cols > csa_pkg::COLS_W'(csa_pkg::MAX_COLUMNS))
                     ? csa_pkg::COLS_W'(csa_pkg::MAX_COLUMNS) : cfg_cols;
   assign eff_rows = (cfg_rows == '0) ? csa_pkg::ROWS_W'(1) : cfg_rows;

   assign col = ({1'b0, col_pos_ff} >= eff_cols) ? '0 : col_pos_ff;
   assign row = (row_pos_ff >= eff_rows) ? '0 : row_pos_ff;

   assign last_col = (({1'b0, col} + csa_pkg::COLS_W'(1)) == eff_cols);
   assign last_row = (({1'b0, row} + 17'd1) == {1'b0, eff_rows});

   assign cur.col        = col;
   assign cur.first_row  = (row == '0);
   assign cur.last_row   = last_row;
   assign cur.last_col   = last_col;
   assign cur.single_col = (eff_cols == csa_pkg::COLS_W'(1));

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (clear) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (advance) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : row + csa_pkg::ROWS_W'(1);
         end else begin
            col_pos_in = col + csa_pkg::COL_W'(1);
            row_pos_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end
endmodule

@@ sv/column_sum_accumulator.sv @@
// Column-sum accumulator: per-column running sums over a row-major sample stream.
//
// req_ch carries one signed 16-bit sample per transfer, rows one after another.
// rsp_ch carries the finished sum of a column, its index and a final-column flag;
// a transfer appears only for samples of the last row of a frame.
// csr_ch writes column_count (index 0) and row_count (index 1); it is always
// ready, and a write to either register restarts the frame at column 0, row 0.
// Write registers only while no sample is in flight.
// Throughput: one sample per cycle while rsp_ch does not stall, set by the sum
// memory, which takes one read and one write per cycle (read at acceptance,
// write-back when the second stage leaves). A back-to-back hit on the same
// column (one-column rows) is forwarded. A sample passes the second-stage
// register, then the output register, before its result is valid on rsp_ch.
// When rsp_ch stalls, one result waits in the output register and one more
// sample may be taken into the second stage; after that req_ch.ready drops.
// Reset: column_count 4096, row_count 1, position 0; the sum memory is not
// cleared, since each entry is loaded on the first row of a frame.
`include "column_sum_accumulator_macros.svh"

module column_sum_accumulator (
   input  logic       clock,
   input  logic       reset,
   csa_req_if.sink    req_ch,
   csa_rsp_if.source  rsp_ch,
   csa_csr_if.sink    csr_ch
);
   logic [csa_pkg::COLS_W-1:0]  cfg_cols_ff;
   logic [csa_pkg::ROWS_W-1:0]  cfg_rows_ff;
   logic                        csr_write;
   logic                        csr_known;
   csa_pkg::pos_type            cur;

   logic                        accept;
   logic                        s1_go;
   logic                        s1_v_ff;
   logic [csa_pkg::COL_W-1:0]   s1_col_ff;
   logic                        s1_first_ff;
   logic                        s1_lrow_ff;
   logic                        s1_lcol_ff;
   logic                        s1_fwd_ff;
   logic signed [csa_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [csa_pkg::SUM_W-1:0]   s1_base;
   logic [csa_pkg::SUM_W-1:0]   s1_sum;

   logic [csa_pkg::SUM_W-1:0]   sum_mem [csa_pkg::MAX_COLUMNS];
   logic [csa_pkg::SUM_W-1:0]   rd_data_ff;
   logic [csa_pkg::SUM_W-1:0]   last_sum_ff;

   logic                        rsp_v_ff;
   logic [csa_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic [csa_pkg::COL_W-1:0]   rsp_col_ff;
   logic                        rsp_last_ff;

   // configuration
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign csr_known    = (csr_ch.index == csa_pkg::REG_COLUMN_COUNT) ||
                         (csr_ch.index == csa_pkg::REG_ROW_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= csa_pkg::COLUMN_COUNT_RESET;
         cfg_rows_ff <= csa_pkg::ROW_COUNT_RESET;
      end else if (csr_write) begin
         if (csr_ch.index == csa_pkg::REG_COLUMN_COUNT) begin
            cfg_cols_ff <= csr_ch.data[csa_pkg::COLS_W-1:0];
         end
         if (csr_ch.index == csa_pkg::REG_ROW_COUNT) begin
            cfg_rows_ff <= csr_ch.data[csa_pkg::ROWS_W-1:0];
         end
      end
   end

   csa_position u_position (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .clear    (csr_write && csr_known),
      .cfg_cols (cfg_cols_ff),
      .cfg_rows (cfg_rows_ff),
      .cur      (cur)
   );

   // second stage leaves unless it holds a result and the output is full
   assign s1_go         = s1_v_ff && (!s1_lrow_ff || !rsp_v_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_v_ff || s1_go;
   assign accept        = req_ch.valid && req_ch.ready;

   assign s1_base = s1_fwd_ff ? last_sum_ff : rd_data_ff;
   assign s1_sum  = (s1_first_ff ? '0 : s1_base) +
                    csa_pkg::SUM_W'(signed'(s1_sample_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s1_fwd_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff   <= 1'b1;
         // same column written at this edge: memory read returns stale data
         s1_fwd_ff <= s1_go && (s1_col_ff == cur.col);
      end else if (s1_go) begin
         s1_v_ff   <= 1'b0;
         s1_fwd_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= cur.col;
         s1_first_ff  <= cur.first_row;
         s1_lrow_ff   <= cur.last_row;
         s1_lcol_ff   <= cur.last_col;
         s1_sample_ff <= req_ch.sample;
      end
   end

   // sum memory: read at acceptance, write back when the second stage leaves
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= sum_mem[cur.col];
      end
      if (s1_go) begin
         sum_mem[s1_col_ff] <= s1_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         last_sum_ff <= s1_sum;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s1_go && s1_lrow_ff) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_lrow_ff) begin
         rsp_sum_ff  <= s1_sum;
         rsp_col_ff  <= s1_col_ff;
         rsp_last_ff <= s1_lcol_ff;
      end
   end

   assign rsp_ch.valid        = rsp_v_ff;
   assign rsp_ch.column_sum   = signed'(rsp_sum_ff);
   assign rsp_ch.column_index = rsp_col_ff;
   assign rsp_ch.last_column  = rsp_last_ff;

   `CSA_ASSERT_NOW(a_fwd_single_col, clock, reset, s1_fwd_ff, s1_v_ff && cur.single_col)
   `CSA_ASSERT_NOW(a_stall_has_result, clock, reset, s1_v_ff && !s1_go,
                   s1_lrow_ff && rsp_v_ff && !rsp_ch.ready)
   `CSA_ASSERT_NEXT(a_result_loaded, clock, reset, s1_go && s1_lrow_ff,
                    rsp_v_ff && rsp_col_ff == $past(s1_col_ff))
endmodule
